/* hw/rtl/mbp_pkg.sv */
package mbp_pkg;

    // Item opcodes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd1;
    localparam logic [1:0] OP_RAW   = 2'd2;

    // Widest field that a write item can append.
    localparam logic [6:0] MAX_FIELD_BITS = 7'd64;

    // Staging buffer: one held byte followed by a full 64-bit field.
    localparam int BUF_W = 72;

    // Input beat.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] field_value;
        logic [6:0]  bit_count;
    } t_in_item;

    // Output beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic shift;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_bytes;
        logic last;
        logic slot_free;
    } t_dp_status;

endpackage

/* hw/rtl/mbp_ctrl.sv */
module mbp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mbp_pkg::t_dp_status i_status,
    output mbp_pkg::t_ctl_cmd  o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic r_state;
    logic n_state;

    // Inputs are taken only while no byte of an earlier item is pending.
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cmd.load  = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.shift = (r_state == ST_EMIT) && i_status.slot_free;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.has_bytes) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.slot_free && i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/mbp_datapath.sv */
module mbp_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbp_pkg::t_ctl_cmd   i_cmd,
    output mbp_pkg::t_dp_status o_status,
    input  mbp_pkg::t_in_item   i_in_data,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output mbp_pkg::t_out_item  o_out_data
);

    logic [7:0]                r_held;      // held bits, left-aligned, zero below
    logic [2:0]                r_held_cnt;
    logic [mbp_pkg::BUF_W-1:0] r_buf;
    logic [6:0]                r_rem;
    logic                      r_out_vld;
    mbp_pkg::t_out_item        r_out;

    logic [6:0]                cnt_sat;
    logic [63:0]               field_left;
    logic [mbp_pkg::BUF_W-1:0] n_buf;
    logic [6:0]                n_total;
    logic                      held_any;
    logic                      slot_free;
    logic                      last;

    // Saturate the count and left-align the new field.
    assign cnt_sat    = (i_in_data.bit_count > mbp_pkg::MAX_FIELD_BITS) ?
                        mbp_pkg::MAX_FIELD_BITS : i_in_data.bit_count;
    assign field_left = i_in_data.field_value << (mbp_pkg::MAX_FIELD_BITS - cnt_sat);
    assign held_any   = (r_held_cnt != 3'd0);

    // Build the staging buffer and its bit count for the new item.
    always_comb begin
        n_buf   = {r_held, 64'd0};
        n_total = {4'd0, r_held_cnt};
        unique case (i_in_data.opcode)
            mbp_pkg::OP_WRITE: begin
                // The new field starts right behind the held bits.
                n_buf   = {r_held, 64'd0} | ({field_left, 8'd0} >> r_held_cnt);
                n_total = {4'd0, r_held_cnt} + cnt_sat;
            end
            mbp_pkg::OP_FLUSH: begin
                n_total = held_any ? 7'd8 : 7'd0;
            end
            mbp_pkg::OP_RAW: begin
                if (held_any) begin
                    n_buf   = {r_held, i_in_data.field_value[7:0], 56'd0};
                    n_total = 7'd16;
                end else begin
                    n_buf   = {i_in_data.field_value[7:0], 64'd0};
                    n_total = 7'd8;
                end
            end
            default: begin
                // The unused opcode leaves the held bits as they are.
                n_buf   = {r_held, 64'd0};
                n_total = {4'd0, r_held_cnt};
            end
        endcase
    end

    assign slot_free = !r_out_vld || !i_out_stall;
    assign last      = (r_rem[6:4] == 3'd0);

    assign o_status.has_bytes = (n_total[6:3] != 4'd0);
    assign o_status.last      = last;
    assign o_status.slot_free = slot_free;

    // Held bits and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= 8'd0;
            r_held_cnt <= 3'd0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.load && (n_total[6:3] == 4'd0)) begin
                // No whole byte: the new partial byte is held at once.
                r_held     <= n_buf[mbp_pkg::BUF_W-1 -: 8];
                r_held_cnt <= n_total[2:0];
            end else if (i_cmd.shift && last) begin
                r_held     <= r_buf[mbp_pkg::BUF_W-9 -: 8];
                r_held_cnt <= r_rem[2:0];
            end
            if (i_cmd.shift) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Staging buffer and output beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_buf <= n_buf;
            r_rem <= n_total;
        end else if (i_cmd.shift) begin
            r_buf <= r_buf << 8;
            r_rem <= r_rem - 7'd8;
        end
        if (i_cmd.shift) begin
            r_out.out_byte    <= r_buf[mbp_pkg::BUF_W-1 -: 8];
            r_out.last_of_run <= last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

/* hw/rtl/msb_first_bit_packer.sv */
// MSB-first bit packer.
// Input channel (i_in_valid / o_in_stall / i_in_data): one beat per item.
// A write item appends the low bit_count bits (saturated at 64) of
// field_value to the held bits; a flush item emits the held bits as one
// left-aligned, zero-padded byte; a raw item flushes, then emits its low byte.
// Output channel (o_out_valid / i_out_stall / o_out_data): one byte per beat,
// last_of_run marks the final byte caused by an item.
// An item is taken in one beat; its bytes then leave one per cycle, while the
// receiver does not stall, from a 72-bit staging shift register, and the input
// is stalled until the last of them is registered (not at all when the item
// completes no byte). The first byte passes through the staging buffer and then the output register.
// The output register lets the next item be taken while the last byte of the
// previous one still waits. When the receiver stalls, the byte shifter waits
// and the input stays stalled until the item's last byte is registered.
// Reset (synchronous, active low) clears the held bits and drops output valid.
module msb_first_bit_packer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mbp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mbp_pkg::t_out_item o_out_data
);

    mbp_pkg::t_ctl_cmd   cmd;
    mbp_pkg::t_dp_status status;

    // Sequencer.
    mbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Staging buffer, held bits and output register.
    mbp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* hw/rtl/mbp_checker.sv */
module mbp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input mbp_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mbp_pkg::t_out_item o_out_data
);

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // Reset leaves the block ready with no output pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // A raw item always produces at least one byte, so the input stalls.
    a_raw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.opcode == mbp_pkg::OP_RAW)
        |=> o_in_stall)
        else $error("raw item did not start emitting");

    // A zero-length write produces nothing and keeps the input open.
    a_zero_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.opcode == mbp_pkg::OP_WRITE)
        && (i_in_data.bit_count == 7'd0) |=> !o_in_stall)
        else $error("zero-length write stalled the input");

    // No byte appears out of an idle block.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("output beat without a pending item");

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

/* tb/msb_first_bit_packer_tb.sv */
`timescale 1ns / 1ps

module msb_first_bit_packer_tb;

    // Opcode 3 has no meaning to the block and must be dropped silently.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles allowed after the last expected byte for stray output beats.
    localparam int DRAIN_CYCLES = 24;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    mbp_pkg::t_in_item  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    mbp_pkg::t_out_item o_out_data;

    // Predictor state: pending bits, right-aligned, and how many there are.
    logic [6:0] pend_bits = '0;
    logic [2:0] pend_cnt = '0;

    // Bytes the packer still owes, oldest first.
    mbp_pkg::t_out_item expected_bytes[$];
    mbp_pkg::t_out_item want_beat;
    int                 mismatch_count = 0;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int         send_gap_pct = 0;
    int         stall_pct = 0;

    msb_first_bit_packer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Predict the bytes that one accepted item produces and queue them.
    function automatic void pack_item(input mbp_pkg::t_in_item item);
        logic [7:0] acc;
        logic [7:0] run_bytes[$];
        int         fill;
        int         nbits;

        case (item.opcode) inside
            mbp_pkg::OP_WRITE: begin
                nbits = (item.bit_count > mbp_pkg::MAX_FIELD_BITS) ?
                        mbp_pkg::MAX_FIELD_BITS : item.bit_count;
                acc = {1'b0, pend_bits};
                fill = pend_cnt;
                // Shift the field in, most significant bit first.
                for (int i = nbits; i > 0; i--) begin
                    acc = {acc[6:0], item.field_value[i-1]};
                    fill++;
                    if (fill == 8) begin
                        run_bytes.push_back(acc);
                        acc = '0;
                        fill = 0;
                    end
                end
                pend_cnt = fill[2:0];
                pend_bits = acc[6:0] & ((7'd1 << fill) - 7'd1);
            end
            mbp_pkg::OP_FLUSH, mbp_pkg::OP_RAW: begin
                // A partial byte leaves left-aligned with zero padding.
                if (pend_cnt != 3'd0) begin
                    acc = {1'b0, pend_bits};
                    acc = acc << (4'd8 - pend_cnt);
                    run_bytes.push_back(acc);
                    pend_bits = '0;
                    pend_cnt = '0;
                end
                if (item.opcode == mbp_pkg::OP_RAW) begin
                    run_bytes.push_back(item.field_value[7:0]);
                end
            end
            default: begin
            end
        endcase

        // The final byte of the run carries the last marker.
        for (int k = 0; k < run_bytes.size(); k++) begin
            expected_bytes.push_back('{out_byte: run_bytes[k],
                                       last_of_run: (k == run_bytes.size() - 1)});
        end
    endfunction

    function automatic mbp_pkg::t_in_item make_item(input logic [1:0] op,
                                                    input logic [63:0] value,
                                                    input logic [6:0] count);
        mbp_pkg::t_in_item item;
        item.opcode = op;
        item.field_value = value;
        item.bit_count = count;
        return item;
    endfunction

    // Mostly write beats with short counts, some long and oversized ones.
    function automatic mbp_pkg::t_in_item random_item();
        mbp_pkg::t_in_item item;
        int                pick;

        pick = $urandom_range(0, 99);
        item.field_value = {$urandom, $urandom};
        if (pick < 68) begin
            item.opcode = mbp_pkg::OP_WRITE;
        end else if (pick < 80) begin
            item.opcode = mbp_pkg::OP_FLUSH;
        end else if (pick < 94) begin
            item.opcode = mbp_pkg::OP_RAW;
        end else begin
            item.opcode = OP_UNUSED;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            item.bit_count = 7'($urandom_range(0, 12));
        end else if (pick < 85) begin
            item.bit_count = 7'($urandom_range(13, 64));
        end else if (pick < 92) begin
            item.bit_count = mbp_pkg::MAX_FIELD_BITS;
        end else begin
            item.bit_count = 7'($urandom_range(65, 127));
        end
        return item;
    endfunction

    // Send one beat, with random idle cycles ahead of it, and predict its bytes.
    task automatic send_item(input mbp_pkg::t_in_item item);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        pack_item(item);
    endtask

    // Hold the input idle until every owed byte has come out.
    task automatic wait_for_output_drain();
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Compare every accepted output beat with the oldest owed byte.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected beat: out_byte=%02h last_of_run=%0b",
                       o_out_data.out_byte, o_out_data.last_of_run);
                mismatch_count++;
            end else begin
                want_beat = expected_bytes.pop_front();
                if (o_out_data.out_byte !== want_beat.out_byte) begin
                    $error("out_byte: expected %02h, got %02h",
                           want_beat.out_byte, o_out_data.out_byte);
                    mismatch_count++;
                end
                if (o_out_data.last_of_run !== want_beat.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b",
                           want_beat.last_of_run, o_out_data.last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // Field lengths from empty to oversized, with values that expose bit order.
    task automatic test_field_lengths();
        send_item(make_item(mbp_pkg::OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0));
        send_item(make_item(mbp_pkg::OP_WRITE, 64'h0000_0000_0000_0001, 7'd1));
        send_item(make_item(mbp_pkg::OP_WRITE, 64'h0000_0000_0000_0055, 7'd7));
        send_item(make_item(mbp_pkg::OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF,
                            mbp_pkg::MAX_FIELD_BITS));
        send_item(make_item(mbp_pkg::OP_WRITE, 64'h0000_0000_0000_0000,
                            mbp_pkg::MAX_FIELD_BITS));
        send_item(make_item(mbp_pkg::OP_WRITE, 64'hFFFF_FFFF_FFFF_FFF5, 7'd3));
        send_item(make_item(mbp_pkg::OP_WRITE, 64'hA5A5_A5A5_A5A5_A5A5, 7'd127));
        send_item(make_item(mbp_pkg::OP_WRITE, 64'h0123_4567_89AB_CDEF, 7'd65));
        send_item(make_item(mbp_pkg::OP_WRITE, 64'h8000_0000_0000_0001, 7'd63));
        send_item(make_item(mbp_pkg::OP_WRITE, 64'h0000_0000_0000_003C, 7'd8));
        send_item(make_item(mbp_pkg::OP_WRITE, 64'h8000_0000_0000_0000,
                            mbp_pkg::MAX_FIELD_BITS));
    endtask

    // Flushes and raw bytes with and without held bits, and the unused opcode.
    task automatic test_flush_and_raw();
        send_item(make_item(mbp_pkg::OP_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127));
        send_item(make_item(mbp_pkg::OP_FLUSH, 64'h0, 7'd0));
        send_item(make_item(mbp_pkg::OP_RAW, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0));
        send_item(make_item(mbp_pkg::OP_WRITE, 64'h1, 7'd1));
        send_item(make_item(mbp_pkg::OP_RAW, 64'hFFFF_FFFF_FFFF_FF00, 7'd127));
        send_item(make_item(mbp_pkg::OP_WRITE, 64'h7F, 7'd7));
        send_item(make_item(mbp_pkg::OP_FLUSH, 64'h0, 7'd0));
        send_item(make_item(mbp_pkg::OP_WRITE, 64'h13, 7'd5));
        send_item(make_item(mbp_pkg::OP_RAW, 64'hA5, 7'd0));
        send_item(make_item(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127));
        send_item(make_item(mbp_pkg::OP_WRITE, 64'h5, 7'd3));
        send_item(make_item(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF,
                            mbp_pkg::MAX_FIELD_BITS));
        send_item(make_item(mbp_pkg::OP_FLUSH, 64'h0, 7'd0));
    endtask

    // Random beats; beats the block ignores do not count toward the total.
    task automatic test_random_stream(input int count);
        mbp_pkg::t_in_item item;
        int                sent;

        sent = 0;
        while (sent < count) begin
            item = random_item();
            send_item(item);
            if (item.opcode != OP_UNUSED) begin
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_gap_pct = 21;
        stall_pct = 74;
        test_field_lengths();
        test_flush_and_raw();
        test_random_stream(86);
        wait_for_output_drain();

        send_gap_pct = 74;
        stall_pct = 21;
        test_random_stream(86);
        wait_for_output_drain();

        send_gap_pct = 0;
        stall_pct = 0;
        test_random_stream(86);

        // Let the last bytes out, then watch for stray beats.
        wait_for_output_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard limit well beyond the slowest correct run.
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
